// ----- sv/cfq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants of the circular fifo queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

  // data word and configuration widths
  localparam int WORD_W       = 32;
  localparam int CAP_CFG_W    = 5;
  localparam int DEFAULT_DEPTH = 16;

  // word reported for front and rear while nothing is held
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // operation codes, any other code is a status query
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic apply;    // item accepted, update pointers and ring
    logic capture;  // register front and rear words and flags
  } cmd_t;

endpackage

// ----- sv/cfq_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_req_if
// Request channel: one queue operation per item.
// ----------------------------------------------------------------------------
interface cfq_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [cfq_pkg::WORD_W-1:0]   push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// ----- sv/cfq_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_rsp_if
// Response channel: status of the queue after each operation.
// ----------------------------------------------------------------------------
interface cfq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic signed [cfq_pkg::WORD_W-1:0]   front_word;
  logic signed [cfq_pkg::WORD_W-1:0]   rear_word;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, output accepted, output front_word, output rear_word,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input accepted, input front_word, input rear_word,
                input is_empty, input is_full, output ready);
endinterface

// ----- sv/circular_fifo_queue.sv -----
`timescale 1ns / 1ps
// After an item is accepted, the sequencer captures its result in ST_READ and
// presents it in ST_SEND until rsp.ready takes it; the request side is ready
// only while the sequencer is idle, so no new item is taken before then.
// Reset empties the queue and sets the capacity to MAX_DEPTH; ring contents
// are not cleared.
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring buffer queue of signed words with a configurable capacity.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
  parameter int MAX_DEPTH = cfq_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  cfq_req_if.sink                       req,
  cfq_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [cfq_pkg::CAP_CFG_W-1:0] cfg_data
);

  cfq_pkg::cmd_t cmd;

  // sequencer
  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // storage and pointers
  cfq_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .opcode     (req.opcode),
    .push_value (req.push_value),
    .accepted   (rsp.accepted),
    .front_word (rsp.front_word),
    .rear_word  (rsp.rear_word),
    .is_empty   (rsp.is_empty),
    .is_full    (rsp.is_full)
  );

endmodule

// ----- sv/cfq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_ctrl
// Sequencer: accept an item, read the ring, present the result.
// ----------------------------------------------------------------------------
module cfq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cfq_pkg::cmd_t cmd
);

  cfq_pkg::state_t state;
  cfq_pkg::state_t state_next;

  // handshake outputs and datapath commands
  assign req_ready   = (state == cfq_pkg::ST_IDLE);
  assign rsp_valid   = (state == cfq_pkg::ST_SEND);
  assign cmd.apply   = (state == cfq_pkg::ST_IDLE) && req_valid;
  assign cmd.capture = (state == cfq_pkg::ST_READ);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cfq_pkg::ST_IDLE: begin
        if (req_valid) state_next = cfq_pkg::ST_READ;
      end
      cfq_pkg::ST_READ: begin
        state_next = cfq_pkg::ST_SEND;
      end
      cfq_pkg::ST_SEND: begin
        if (rsp_ready) state_next = cfq_pkg::ST_IDLE;
      end
      default: begin
        state_next = cfq_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/cfq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_datapath
// Ring storage, head and tail pointers, entry count and capacity register.
// ----------------------------------------------------------------------------
module cfq_datapath #(
  parameter int MAX_DEPTH = cfq_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cfq_pkg::cmd_t                       cmd,
  input  logic                                cfg_we,
  input  logic [cfq_pkg::CAP_CFG_W-1:0]       cfg_data,
  input  logic [1:0]                          opcode,
  input  logic signed [cfq_pkg::WORD_W-1:0]   push_value,
  output logic                                accepted,
  output logic signed [cfq_pkg::WORD_W-1:0]   front_word,
  output logic signed [cfq_pkg::WORD_W-1:0]   rear_word,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);

  logic signed [cfq_pkg::WORD_W-1:0] ring [MAX_DEPTH];

  logic [CW-1:0] capacity;
  logic [CW-1:0] count;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;

  logic [31:0]   cfg_wide;
  logic [CW-1:0] cap_clamped;
  logic [CW-1:0] head_inc;
  logic [CW-1:0] tail_inc;
  logic [IW-1:0] head_wrap;
  logic [IW-1:0] tail_wrap;
  logic          can_push;
  logic          can_pop;
  logic          do_push;
  logic          do_pop;

  logic signed [cfq_pkg::WORD_W-1:0] front_r;
  logic signed [cfq_pkg::WORD_W-1:0] rear_r;
  logic                              ok_r;
  logic                              empty_r;
  logic                              full_r;

  // capacity clamp: zero reads as one, large values saturate
  always_comb begin
    cfg_wide = 32'(cfg_data);
    if (cfg_wide == 32'd0) begin
      cap_clamped = CW'(1);
    end else if (cfg_wide > 32'(MAX_DEPTH)) begin
      cap_clamped = CW'(MAX_DEPTH);
    end else begin
      cap_clamped = CW'(cfg_wide);
    end
  end

  // pointer advance with wrap at capacity
  always_comb begin
    head_inc  = CW'(head) + CW'(1);
    tail_inc  = CW'(tail) + CW'(1);
    head_wrap = (head_inc >= capacity) ? '0 : IW'(head_inc);
    tail_wrap = (tail_inc >= capacity) ? '0 : IW'(tail_inc);
  end

  // operation decode
  always_comb begin
    can_push = (count < capacity);
    can_pop  = (count != '0);
    do_push  = cmd.apply && (opcode == cfq_pkg::OP_ENQUEUE) && can_push;
    do_pop   = cmd.apply && (opcode == cfq_pkg::OP_DEQUEUE) && can_pop;
  end

  // pointers, count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(MAX_DEPTH);
      head     <= '0;
      tail     <= IW'(MAX_DEPTH - 1);
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cap_clamped;
      head     <= '0;
      tail     <= IW'(cap_clamped - CW'(1));
      count    <= '0;
    end else begin
      if (do_push) begin
        tail  <= tail_wrap;
        count <= count + CW'(1);
      end
      if (do_pop) begin
        head  <= head_wrap;
        count <= count - CW'(1);
      end
    end
  end

  // success flag of the current item
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      unique case (opcode)
        cfq_pkg::OP_ENQUEUE: ok_r <= can_push;
        cfq_pkg::OP_DEQUEUE: ok_r <= can_pop;
        default:             ok_r <= 1'b1;
      endcase
    end
  end

  // ring write port
  always_ff @(posedge clk) begin
    if (do_push) begin
      ring[tail_wrap] <= push_value;
    end
  end

  // ring read ports and flags, taken after the update has settled
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      front_r <= ring[head];
      rear_r  <= ring[tail];
      empty_r <= (count == '0);
      full_r  <= (count == capacity);
    end
  end

  // result fields
  assign accepted   = ok_r;
  assign is_empty   = empty_r;
  assign is_full    = full_r;
  assign front_word = empty_r ? cfq_pkg::EMPTY_WORD : front_r;
  assign rear_word  = empty_r ? cfq_pkg::EMPTY_WORD : rear_r;

endmodule
